FILE: rtl/core/ps2kc_pkg.sv
// Package with the constants, codes and shared types of the PS/2 keyboard controller.
`timescale 1ns / 1ps
`default_nettype none
package ps2kc_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int BANK_DEPTH = (FIFO_DEPTH + 1) / 2;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam logic [1:0] OP_BUS_WRITE = 2'd0;
    localparam logic [1:0] OP_BUS_READ  = 2'd1;
    localparam logic [1:0] OP_KEY_EVENT = 2'd2;

    localparam logic [15:0] PORT_DATA   = 16'h1060;
    localparam logic [15:0] PORT_STATUS = 16'h1064;

    localparam logic [7:0] CMD_SELF_TEST    = 8'hAA;
    localparam logic [7:0] CMD_IF_TEST      = 8'hAB;
    localparam logic [7:0] CMD_MOUSE_ENABLE = 8'hA8;
    localparam logic [7:0] CMD_MOUSE_TEST   = 8'hA9;
    localparam logic [7:0] CMD_READ_CB      = 8'h20;
    localparam logic [7:0] CMD_WRITE_CB     = 8'h60;
    localparam logic [7:0] KBD_ENABLE       = 8'hF4;

    localparam logic [7:0] RESP_ACK       = 8'hFA;
    localparam logic [7:0] RESP_ZERO      = 8'h00;
    localparam logic [7:0] RESP_SELF_TEST = 8'h55;
    localparam logic [7:0] PREFIX_EXT     = 8'hE0;

    localparam logic [7:0] STATUS_AFTER_CMD = 8'h0C;
    localparam logic [7:0] STATUS_UNLOCKED  = 8'h10;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic [6:0]  key_code;
        logic        key_extended;
        logic        key_release;
    } cmd_t;

    typedef struct packed {
        logic       push_a;
        logic [7:0] data_a;
        logic       push_b;
        logic [7:0] data_b;
        logic       pop;
    } fifo_req_t;

    typedef struct packed {
        logic not_empty;
        logic one_left;
        logic overflow;
    } fifo_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/ps2kc_if.sv
// Handshake interfaces for the command items and the result items.
`timescale 1ns / 1ps
`default_nettype none
interface ps2kc_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic [6:0]  key_code;
    logic        key_extended;
    logic        key_release;

    modport source (
        output valid, operation, bus_address, write_data, key_code, key_extended,
               key_release,
        input  ready
    );
    modport sink (
        input  valid, operation, bus_address, write_data, key_code, key_extended,
               key_release,
        output ready
    );
endinterface

interface ps2kc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_level;
    logic       fifo_overflow;

    modport source (
        output valid, read_data, irq_level, fifo_overflow,
        input  ready
    );
    modport sink (
        input  valid, read_data, irq_level, fifo_overflow,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/ps2kc_fifo.sv
// Output byte FIFO in two interleaved banks, taking up to two pushes and one pop an item.
`timescale 1ns / 1ps
`default_nettype none
module ps2kc_fifo
    import ps2kc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire fifo_req_t  req,
    output fifo_stat_t      stat,
    output logic [7:0]      rd_data
);

    // Successive bytes alternate between the banks, so two pushes never meet in one bank.
    logic [7:0]         mem_bank0 [BANK_DEPTH];
    logic [7:0]         mem_bank1 [BANK_DEPTH];
    logic [BANK_AW-1:0] wr_ptr_reg [2];
    logic [BANK_AW-1:0] rd_ptr_reg [2];
    logic [BANK_AW-1:0] wr_ptr_next [2];
    logic [BANK_AW-1:0] rd_ptr_next [2];
    logic               tail_bank_reg;
    logic               tail_bank_next;
    logic               head_bank_reg;
    logic               head_bank_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   count_after_a;
    logic [7:0]         q_reg;
    logic               ok_a;
    logic               ok_b;
    logic               pop_ok;
    logic               bank_b;
    logic [1:0]         we;
    logic [7:0]         wdata [2];

    function automatic logic [BANK_AW-1:0] ptr_inc(input logic [BANK_AW-1:0] p);
        logic [BANK_AW-1:0] r;
        if (p == BANK_AW'(BANK_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + BANK_AW'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        ok_a          = req.push_a && (count_reg < CNT_W'(FIFO_DEPTH));
        count_after_a = count_reg + CNT_W'(ok_a);
        ok_b          = req.push_b && (count_after_a < CNT_W'(FIFO_DEPTH));
        pop_ok        = req.pop && (count_reg != '0);
        bank_b        = tail_bank_reg ^ ok_a;

        we       = 2'b00;
        wdata[0] = req.data_b;
        wdata[1] = req.data_b;
        if (ok_a)
        begin
            we[tail_bank_reg]    = 1'b1;
            wdata[tail_bank_reg] = req.data_a;
        end
        if (ok_b)
        begin
            we[bank_b]    = 1'b1;
            wdata[bank_b] = req.data_b;
        end

        for (int b = 0; b < 2; b++)
        begin
            wr_ptr_next[b] = we[b] ? ptr_inc(wr_ptr_reg[b]) : wr_ptr_reg[b];
            rd_ptr_next[b] = rd_ptr_reg[b];
        end
        if (pop_ok)
        begin
            rd_ptr_next[head_bank_reg] = ptr_inc(rd_ptr_reg[head_bank_reg]);
        end

        tail_bank_next = tail_bank_reg ^ ok_a ^ ok_b;
        head_bank_next = head_bank_reg ^ pop_ok;
        count_next     = count_after_a + CNT_W'(ok_b) - CNT_W'(pop_ok);

        stat.not_empty = (count_reg != '0);
        stat.one_left  = (count_reg == CNT_W'(1));
        stat.overflow  = (req.push_a && !ok_a) || (req.push_b && !ok_b);
        rd_data        = q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < 2; b++)
            begin
                wr_ptr_reg[b] <= '0;
                rd_ptr_reg[b] <= '0;
            end
            tail_bank_reg <= 1'b0;
            head_bank_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            for (int b = 0; b < 2; b++)
            begin
                wr_ptr_reg[b] <= wr_ptr_next[b];
                rd_ptr_reg[b] <= rd_ptr_next[b];
            end
            tail_bank_reg <= tail_bank_next;
            head_bank_reg <= head_bank_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we[0])
        begin
            mem_bank0[wr_ptr_reg[0]] <= wdata[0];
        end
        if (we[1])
        begin
            mem_bank1[wr_ptr_reg[1]] <= wdata[1];
        end
        if (pop_ok)
        begin
            if (head_bank_reg)
            begin
                q_reg <= mem_bank1[rd_ptr_reg[1]];
            end
            else
            begin
                q_reg <= mem_bank0[rd_ptr_reg[0]];
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/ps2kc_top_dummy_guard.sv
// Result stage of the controller: holds one result item and its byte source until taken.
`timescale 1ns / 1ps
`default_nettype none
module ps2kc_rsp_stage
    import ps2kc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  wire logic  take,
    input  wire logic  sel_fifo,
    input  wire logic [7:0] byte_in,
    input  wire logic  irq_in,
    input  wire logic  overflow_in,
    input  wire logic [7:0] fifo_byte,
    output logic       valid,
    output logic [7:0] read_data,
    output logic       irq_level,
    output logic       fifo_overflow
);

    logic       valid_reg;
    logic       valid_next;
    logic       sel_fifo_reg;
    logic [7:0] byte_reg;
    logic       irq_reg;
    logic       overflow_reg;

    always_comb
    begin
        valid_next    = load ? 1'b1 : (take ? 1'b0 : valid_reg);
        valid         = valid_reg;
        // A popped byte comes straight from the FIFO's registered read port.
        read_data     = sel_fifo_reg ? fifo_byte : byte_reg;
        irq_level     = irq_reg;
        fifo_overflow = overflow_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sel_fifo_reg <= sel_fifo;
            byte_reg     <= byte_in;
            irq_reg      <= irq_in;
            overflow_reg <= overflow_in;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/ps2_keyboard_controller_ports_unit.sv
// Top level of the 8042-style PS/2 keyboard controller behind a data port and a status port.
//
//   channel  direction  fields
//   cmd      in         operation, bus_address, write_data, key_code, key_extended, key_release
//   rsp      out        read_data, irq_level, fifo_overflow
//
// Every item passes from acceptance to result through the input register, where it is decoded and
// updates the FIFO and flags, and then the result register. One item is accepted per cycle
// when not stalled; the FIFO's two interleaved banks take a key event's prefix and code together.
// Reset clears the flags, the command byte and the FIFO pointers; the FIFO storage is not cleared.
// A stalled result holds the input register, and the input side stalls only when both are full.
`timescale 1ns / 1ps
`default_nettype none
module ps2_keyboard_controller_ports_unit
    import ps2kc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ps2kc_cmd_if.sink   cmd,
    ps2kc_rsp_if.source rsp
);

    logic       in_valid_reg;
    logic       in_valid_next;
    cmd_t       in_reg;
    logic       step;
    logic       out_free;
    logic       rsp_valid;

    logic       cmd_seen_reg;
    logic       cmd_seen_next;
    logic [7:0] command_byte_reg;
    logic [7:0] command_byte_next;
    logic       expect_command_reg;
    logic       expect_command_next;
    logic       irq_reg;
    logic       irq_next;

    fifo_req_t  fifo_req;
    fifo_req_t  req_raw;
    fifo_stat_t fifo_stat;
    logic [7:0] fifo_byte;
    logic [7:0] rd_byte;
    logic       rd_from_fifo;

    always_comb
    begin
        out_free      = !rsp_valid || rsp.ready;
        step          = in_valid_reg && out_free;
        cmd.ready     = !in_valid_reg || out_free;
        in_valid_next = (cmd.valid && cmd.ready) ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    end

    always_comb
    begin
        req_raw.push_a      = 1'b0;
        req_raw.data_a      = PREFIX_EXT;
        req_raw.push_b      = 1'b0;
        req_raw.data_b      = RESP_ZERO;
        req_raw.pop         = 1'b0;
        cmd_seen_next       = cmd_seen_reg;
        command_byte_next   = command_byte_reg;
        expect_command_next = expect_command_reg;
        irq_next            = irq_reg;
        rd_byte             = 8'h00;
        rd_from_fifo        = 1'b0;

        case (in_reg.operation)
            OP_BUS_WRITE:
            begin
                if (in_reg.bus_address == PORT_DATA)
                begin
                    if (expect_command_reg)
                    begin
                        command_byte_next   = in_reg.write_data;
                        expect_command_next = 1'b0;
                    end
                    else
                    begin
                        req_raw.push_b = 1'b1;
                        req_raw.data_b = (in_reg.write_data == KBD_ENABLE) ? RESP_ACK : RESP_ZERO;
                    end
                end
                else if (in_reg.bus_address == PORT_STATUS)
                begin
                    case (in_reg.write_data)
                        CMD_SELF_TEST:
                        begin
                            req_raw.push_b = 1'b1;
                            req_raw.data_b = RESP_SELF_TEST;
                            cmd_seen_next  = 1'b1;
                        end
                        CMD_IF_TEST, CMD_MOUSE_TEST:
                        begin
                            req_raw.push_b = 1'b1;
                            cmd_seen_next  = 1'b1;
                        end
                        CMD_MOUSE_ENABLE:
                        begin
                            cmd_seen_next = 1'b1;
                        end
                        CMD_READ_CB:
                        begin
                            req_raw.push_b = 1'b1;
                            req_raw.data_b = command_byte_reg;
                            cmd_seen_next  = 1'b1;
                        end
                        CMD_WRITE_CB:
                        begin
                            expect_command_next = 1'b1;
                            cmd_seen_next       = 1'b1;
                        end
                        default:
                        begin
                            cmd_seen_next = cmd_seen_reg;
                        end
                    endcase
                end
            end
            OP_BUS_READ:
            begin
                if (in_reg.bus_address == PORT_STATUS)
                begin
                    rd_byte = (cmd_seen_reg ? STATUS_AFTER_CMD : 8'h00) | STATUS_UNLOCKED
                              | {7'b0, fifo_stat.not_empty};
                end
                else if (in_reg.bus_address == PORT_DATA)
                begin
                    req_raw.pop  = 1'b1;
                    rd_from_fifo = fifo_stat.not_empty;
                    if (!fifo_stat.not_empty || fifo_stat.one_left)
                    begin
                        irq_next = 1'b0;
                    end
                end
            end
            OP_KEY_EVENT:
            begin
                req_raw.push_a = in_reg.key_extended;
                req_raw.push_b = 1'b1;
                req_raw.data_b = {in_reg.key_release, in_reg.key_code};
                irq_next       = 1'b1;
            end
            default:
            begin
                irq_next = irq_reg;
            end
        endcase

        fifo_req        = req_raw;
        fifo_req.push_a = req_raw.push_a && step;
        fifo_req.push_b = req_raw.push_b && step;
        fifo_req.pop    = req_raw.pop && step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            cmd_seen_reg       <= 1'b0;
            command_byte_reg   <= 8'h00;
            expect_command_reg <= 1'b0;
            irq_reg            <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (step)
            begin
                cmd_seen_reg       <= cmd_seen_next;
                command_byte_reg   <= command_byte_next;
                expect_command_reg <= expect_command_next;
                irq_reg            <= irq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_reg.operation    <= cmd.operation;
            in_reg.bus_address  <= cmd.bus_address;
            in_reg.write_data   <= cmd.write_data;
            in_reg.key_code     <= cmd.key_code;
            in_reg.key_extended <= cmd.key_extended;
            in_reg.key_release  <= cmd.key_release;
        end
    end

    ps2kc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (fifo_req),
        .stat    (fifo_stat),
        .rd_data (fifo_byte)
    );

    ps2kc_rsp_stage u_rsp (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (step),
        .take          (rsp.ready),
        .sel_fifo      (rd_from_fifo),
        .byte_in       (rd_byte),
        .irq_in        (irq_next),
        .overflow_in   (fifo_stat.overflow),
        .fifo_byte     (fifo_byte),
        .valid         (rsp_valid),
        .read_data     (rsp.read_data),
        .irq_level     (rsp.irq_level),
        .fifo_overflow (rsp.fifo_overflow)
    );

    assign rsp.valid = rsp_valid;

endmodule
`default_nettype wire

FILE: bench/ps2kc_response_checker.sv
// Checker that predicts every result of the keyboard controller and compares it with the DUT.
`timescale 1ns / 1ps
module ps2kc_response_checker
    import ps2kc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ps2kc_cmd_if      cmd,
    ps2kc_rsp_if      rsp,
    output int        mismatch_count,
    output int        outstanding
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_level;
        logic       fifo_overflow;
    } kbd_result_t;

    kbd_result_t expected_q[$];

    logic [7:0] fifo_mem [FIFO_DEPTH];
    int         fifo_rd;
    int         fifo_wr;
    int         fifo_fill;
    logic [7:0] status_reg;
    logic [7:0] command_reg;
    logic       cb_load_armed;
    logic       irq_line;
    logic       byte_dropped;

    initial
    begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 50)
        begin
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    function automatic void push_byte(input logic [7:0] b);
        if (fifo_fill >= FIFO_DEPTH)
        begin
            byte_dropped = 1'b1;
        end
        else
        begin
            fifo_mem[fifo_wr] = b;
            fifo_wr = (fifo_wr + 1) % FIFO_DEPTH;
            fifo_fill++;
        end
    endfunction

    function automatic logic [7:0] pop_byte();
        logic [7:0] b;
        b = RESP_ZERO;
        if (fifo_fill != 0)
        begin
            b = fifo_mem[fifo_rd];
            fifo_rd = (fifo_rd + 1) % FIFO_DEPTH;
            fifo_fill--;
        end
        return b;
    endfunction

    function automatic kbd_result_t predict_response(input cmd_t c);
        kbd_result_t r;
        logic        recognised;
        r            = '0;
        recognised   = 1'b1;
        byte_dropped = 1'b0;
        case (c.operation)
            OP_BUS_WRITE:
            begin
                if (c.bus_address == PORT_DATA)
                begin
                    if (cb_load_armed)
                    begin
                        command_reg   = c.write_data;
                        cb_load_armed = 1'b0;
                    end
                    else
                    begin
                        push_byte(c.write_data == KBD_ENABLE ? RESP_ACK : RESP_ZERO);
                    end
                end
                else if (c.bus_address == PORT_STATUS)
                begin
                    case (c.write_data)
                        CMD_SELF_TEST:               push_byte(RESP_SELF_TEST);
                        CMD_IF_TEST, CMD_MOUSE_TEST: push_byte(RESP_ZERO);
                        CMD_MOUSE_ENABLE:            ;
                        CMD_READ_CB:                 push_byte(command_reg);
                        CMD_WRITE_CB:                cb_load_armed = 1'b1;
                        default:                     recognised = 1'b0;
                    endcase
                    if (recognised)
                    begin
                        status_reg = STATUS_AFTER_CMD;
                    end
                end
            end
            OP_BUS_READ:
            begin
                if (c.bus_address == PORT_STATUS)
                begin
                    r.read_data = status_reg | STATUS_UNLOCKED | {7'd0, fifo_fill != 0};
                end
                else if (c.bus_address == PORT_DATA)
                begin
                    r.read_data = pop_byte();
                    if (fifo_fill == 0)
                    begin
                        irq_line = 1'b0;
                    end
                end
            end
            OP_KEY_EVENT:
            begin
                if (c.key_extended)
                begin
                    push_byte(PREFIX_EXT);
                end
                push_byte({c.key_release, c.key_code});
                irq_line = 1'b1;
            end
            default: ;
        endcase
        r.irq_level     = irq_line;
        r.fifo_overflow = byte_dropped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        kbd_result_t want;
        kbd_result_t pred;
        cmd_t        seen;
        if (!rst_n)
        begin
            fifo_rd       = 0;
            fifo_wr       = 0;
            fifo_fill     = 0;
            status_reg    = 8'h00;
            command_reg   = 8'h00;
            cb_load_armed = 1'b0;
            irq_line      = 1'b0;
            byte_dropped  = 1'b0;
            expected_q.delete();
            outstanding   = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    flag_mismatch("result with nothing expected", int'(rsp.read_data), 0);
                end
                else
                begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    if (rsp.read_data !== want.read_data)
                    begin
                        flag_mismatch("read_data", int'(rsp.read_data), int'(want.read_data));
                    end
                    if (rsp.irq_level !== want.irq_level)
                    begin
                        flag_mismatch("irq_level", int'(rsp.irq_level), int'(want.irq_level));
                    end
                    if (rsp.fifo_overflow !== want.fifo_overflow)
                    begin
                        flag_mismatch("fifo_overflow", int'(rsp.fifo_overflow),
                                      int'(want.fifo_overflow));
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                seen = {cmd.operation, cmd.bus_address, cmd.write_data, cmd.key_code,
                        cmd.key_extended, cmd.key_release};
                pred = predict_response(seen);
                expected_q.insert(expected_q.size(), pred);
            end
            outstanding = expected_q.size();
        end
    end

endmodule

FILE: bench/tb_ps2_keyboard_controller_ports_unit.sv
// Testbench top: clock, reset, host and key stimulus, result back-pressure and the verdict.
`timescale 1ns / 1ps
module tb_ps2_keyboard_controller_ports_unit;
    import ps2kc_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         ITEM_TOTAL  = 1950;
    localparam int         QUIET_FROM  = 800;
    localparam int         QUIET_TO    = 1100;
    localparam int         HOLD_AT     = 300;
    localparam int         HOLD_LEN    = 150;
    localparam int         STALL_LIMIT = 4000;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   outstanding;
    int   items_sent;
    int   results_taken;
    int   idle_cycles;

    ps2kc_cmd_if cmd_ch ();
    ps2kc_rsp_if rsp_ch ();

    ps2_keyboard_controller_ports_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    ps2kc_response_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic quiet_window();
        return items_sent >= QUIET_FROM && items_sent <= QUIET_TO;
    endfunction

    function automatic cmd_t scrambled_cmd();
        cmd_t c;
        c.operation    = 2'($urandom_range(0, 3));
        c.bus_address  = 16'($urandom_range(0, 65535));
        c.write_data   = 8'($urandom_range(0, 255));
        c.key_code     = 7'($urandom_range(0, 127));
        c.key_extended = 1'($urandom_range(0, 1));
        c.key_release  = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic offer_cmd(input cmd_t c);
        while (!quiet_window() && $urandom_range(0, 99) < 8)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.operation    <= c.operation;
        cmd_ch.bus_address  <= c.bus_address;
        cmd_ch.write_data   <= c.write_data;
        cmd_ch.key_code     <= c.key_code;
        cmd_ch.key_extended <= c.key_extended;
        cmd_ch.key_release  <= c.key_release;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic host_write(input logic [15:0] addr, input logic [7:0] data);
        cmd_t c;
        c             = scrambled_cmd();
        c.operation   = OP_BUS_WRITE;
        c.bus_address = addr;
        c.write_data  = data;
        offer_cmd(c);
    endtask

    task automatic host_read(input logic [15:0] addr);
        cmd_t c;
        c             = scrambled_cmd();
        c.operation   = OP_BUS_READ;
        c.bus_address = addr;
        offer_cmd(c);
    endtask

    task automatic key_press(input logic [6:0] code, input logic ext, input logic rel);
        cmd_t c;
        c              = scrambled_cmd();
        c.operation    = OP_KEY_EVENT;
        c.key_code     = code;
        c.key_extended = ext;
        c.key_release  = rel;
        offer_cmd(c);
    endtask

    function automatic logic [7:0] host_command();
        case ($urandom_range(0, 6))
            0:       return CMD_SELF_TEST;
            1:       return CMD_IF_TEST;
            2:       return CMD_MOUSE_ENABLE;
            3:       return CMD_MOUSE_TEST;
            4:       return CMD_READ_CB;
            5:       return CMD_WRITE_CB;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] data_byte();
        return ($urandom_range(0, 3) == 0) ? KBD_ENABLE : 8'($urandom_range(0, 255));
    endfunction

    initial
    begin : stimulus
        cmd_t        c;
        int          pick;
        int          n;
        logic [7:0]  hc;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.operation    <= OP_BUS_WRITE;
        cmd_ch.bus_address  <= 16'h0000;
        cmd_ch.write_data   <= 8'h00;
        cmd_ch.key_code     <= 7'h00;
        cmd_ch.key_extended <= 1'b0;
        cmd_ch.key_release  <= 1'b0;
        items_sent = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        host_read(PORT_STATUS);
        host_read(PORT_DATA);
        host_write(PORT_STATUS, CMD_SELF_TEST);
        host_read(PORT_STATUS);
        host_write(PORT_STATUS, CMD_IF_TEST);
        host_write(PORT_STATUS, CMD_MOUSE_ENABLE);
        host_write(PORT_STATUS, CMD_MOUSE_TEST);
        host_write(PORT_STATUS, CMD_WRITE_CB);
        host_write(PORT_DATA, 8'hFF);
        host_write(PORT_STATUS, CMD_READ_CB);
        host_write(PORT_DATA, KBD_ENABLE);
        host_write(PORT_DATA, 8'h00);
        host_write(PORT_STATUS, 8'h00);
        host_write(16'hFFFF, CMD_SELF_TEST);
        host_read(16'h0000);
        key_press(7'h7F, 1'b1, 1'b1);
        key_press(7'h00, 1'b0, 1'b0);
        c           = '1;
        c.operation = OP_UNUSED;
        offer_cmd(c);
        repeat (7) host_read(PORT_DATA);

        while (items_sent < ITEM_TOTAL)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                hc = host_command();
                host_write(PORT_STATUS, hc);
                if (hc == CMD_WRITE_CB && $urandom_range(0, 99) < 85)
                begin
                    host_write(PORT_DATA, data_byte());
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    host_read(PORT_DATA);
                end
            end
            else if (pick < 32)
            begin
                host_write(PORT_DATA, data_byte());
            end
            else if (pick < 52)
            begin
                key_press(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
            else if (pick < 60)
            begin
                n = $urandom_range(20, 45);
                repeat (n)
                begin
                    key_press(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end
            end
            else if (pick < 75)
            begin
                n = $urandom_range(1, 70);
                repeat (n) host_read(PORT_DATA);
            end
            else if (pick < 85)
            begin
                host_read(PORT_STATUS);
            end
            else
            begin
                c = scrambled_cmd();
                if ($urandom_range(0, 1) == 0)
                begin
                    c.bus_address = (($urandom_range(0, 1) == 0) ? PORT_DATA : PORT_STATUS)
                                    ^ (16'd1 << $urandom_range(0, 15));
                end
                offer_cmd(c);
            end
        end
        cmd_ch.valid <= 1'b0;

        @(posedge clk);
        wait (outstanding == 0);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("ps2_keyboard_controller_ports_unit: match");
        end
        else
        begin
            $display("ps2_keyboard_controller_ports_unit: mismatch");
        end
        $finish;
    end

    initial
    begin : receiver
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!hold_done && results_taken >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= quiet_window() || ($urandom_range(0, 99) >= 8);
            end
            @(posedge clk);
        end
    end

    initial
    begin
        results_taken = 0;
        idle_cycles   = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_taken <= results_taken + 1;
            end
            if ((rsp_ch.valid && rsp_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("ps2_keyboard_controller_ports_unit: mismatch");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
